[hw/rtl/pfgr_pkg.sv]
`timescale 1ns / 1ps

package pfgr_pkg;

    localparam int GAIN_W = 32;
    localparam int MANT_W = 24;
    localparam int EXP_W  = 8;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_GAIN   = 2'd0;
    localparam logic [OP_W-1:0] OP_FILTER = 2'd1;
    localparam logic [OP_W-1:0] OP_LINEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic CFG_RAMP_ENABLE    = 1'b0;
    localparam logic CFG_FILTER_MINIMUM = 1'b1;

    // renormalization window of the mantissa
    localparam logic signed [MANT_W+1:0] NORM_LOW  = 26'sh0400000;
    localparam logic        [MANT_W:0]   NORM_HIGH = 25'h07FFFFF;

endpackage

[hw/rtl/pseudo_float_gain_ramp_step.sv]
`timescale 1ns / 1ps

// Gain ramp step. A request is taken on every clock at which start is high; busy never
// rises, so requests may follow each other back to back. Each request gives one result on
// new_gain and reached, marked by a one-cycle done strobe; the request passes through
// req_valid_reg into done_reg, and the result into new_gain_reg and reached_reg.
// The result is held for that single cycle only: the receiver cannot stall, so it
// must take every result as it appears. Between request and result lie the input register and
// the result register around one combinational pass (exponent alignment shift, mantissa
// add and signed 32-bit clamp compare). Configuration writes take effect at once and are
// to be made only with no request in flight.
module pseudo_float_gain_ramp_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pfgr_pkg::OP_W-1:0]     operation,
    input  logic [pfgr_pkg::GAIN_W-1:0]   current_gain,
    input  logic [pfgr_pkg::GAIN_W-1:0]   target_gain,
    input  logic [pfgr_pkg::GAIN_W-1:0]   step_size,
    input  logic                          ramp_up,
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [pfgr_pkg::GAIN_W-1:0]   cfg_data,
    output logic                          done,
    output logic [pfgr_pkg::GAIN_W-1:0]   new_gain,
    output logic                          reached
);

    import pfgr_pkg::*;

    logic                       ramp_enable_reg;
    logic signed [GAIN_W-1:0]   filter_minimum_reg;

    logic                       req_valid_reg;
    logic [OP_W-1:0]            op_reg;
    logic signed [GAIN_W-1:0]   cur_reg;
    logic signed [GAIN_W-1:0]   dst_reg;
    logic signed [GAIN_W-1:0]   step_reg;
    logic                       up_reg;

    logic                       done_reg;
    logic [GAIN_W-1:0]          new_gain_reg;
    logic                       reached_reg;

    logic signed [GAIN_W-1:0]   result_next;

    // operation 0
    logic signed [EXP_W+1:0]    g_sx;
    logic signed [EXP_W+1:0]    g_sdx;
    logic signed [EXP_W+1:0]    g_de;
    logic signed [EXP_W+1:0]    g_sft;
    logic signed [EXP_W+1:0]    g_shamt;
    logic signed [EXP_W+1:0]    g_ex;
    logic signed [EXP_W+1:0]    g_ex_d;
    logic signed [EXP_W+1:0]    g_ex_u;
    logic [MANT_W-1:0]          g_sm;
    logic [MANT_W-1:0]          g_wrk;
    logic signed [GAIN_W-1:0]   g_src;
    logic signed [MANT_W+1:0]   g_kd;
    logic [MANT_W:0]            g_ku;
    logic signed [GAIN_W-1:0]   g_ret_d;
    logic signed [GAIN_W-1:0]   g_ret_u;
    logic signed [GAIN_W-1:0]   g_res;

    // operation 1
    logic signed [GAIN_W-1:0]   f_src;
    logic signed [GAIN_W-1:0]   f_dst;
    logic [MANT_W-1:0]          f_wrk;
    logic signed [MANT_W+1:0]   f_kd;
    logic [MANT_W:0]            f_ku;
    logic signed [GAIN_W-1:0]   f_ret_d;
    logic signed [GAIN_W-1:0]   f_ret_u;
    logic signed [GAIN_W-1:0]   f_res;

    // operation 2
    logic signed [GAIN_W:0]     l_sum;
    logic signed [GAIN_W:0]     l_dst;
    logic signed [GAIN_W:0]     l_w;
    logic signed [GAIN_W-1:0]   l_res;

    assign busy     = 1'b0;
    assign done     = done_reg;
    assign new_gain = new_gain_reg;
    assign reached  = reached_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_enable_reg    <= 1'b1;
            filter_minimum_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RAMP_ENABLE:    ramp_enable_reg    <= cfg_data[0];
                CFG_FILTER_MINIMUM: filter_minimum_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
            done_reg      <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg   <= operation;
            cur_reg  <= current_gain;
            dst_reg  <= target_gain;
            step_reg <= step_size;
            up_reg   <= ramp_up;
        end
        if (req_valid_reg)
        begin
            new_gain_reg <= result_next;
            reached_reg  <= (result_next == dst_reg);
        end
    end

    // pseudo-float gain step
    always_comb
    begin
        g_sx    = $signed({{2{cur_reg[31]}}, cur_reg[31:24]});
        g_sdx   = $signed({{2{dst_reg[31]}}, dst_reg[31:24]});
        g_de    = $signed({{2{step_reg[31]}}, step_reg[31:24]});
        g_sft   = g_sx - g_de;
        g_shamt = -g_sft;
        g_sm    = '0;
        if (g_sft <= 10'sd0)
        begin
            g_ex  = g_sx;
            g_src = cur_reg;
            g_wrk = (g_shamt >= 10'sd24) ? '0 : (step_reg[23:0] >> g_shamt[4:0]);
        end
        else
        begin
            g_ex  = g_de;
            g_sm  = (g_sft >= 10'sd24) ? '0 : (cur_reg[23:0] >> g_sft[4:0]);
            g_src = {step_reg[31:24], g_sm};
            g_wrk = step_reg[23:0];
        end
        if (g_wrk == '0)
            g_wrk = 24'd1;

        g_kd   = $signed({2'b00, g_src[23:0]}) - $signed({2'b00, g_wrk});
        g_ex_d = g_ex;
        if (g_kd < NORM_LOW && g_ex < g_sdx)
        begin
            g_kd   = g_kd <<< 1;
            g_ex_d = g_ex + 10'sd1;
        end
        g_ret_d = {g_ex_d[7:0], 24'b0} | {{6{g_kd[25]}}, g_kd};
        if ((g_ex_d == g_sdx && g_ret_d <= dst_reg) || g_kd <= 26'sd0)
            g_ret_d = dst_reg;

        g_ku   = {1'b0, g_src[23:0]} + {1'b0, g_wrk};
        g_ex_u = g_ex;
        if (g_ku > NORM_HIGH)
        begin
            g_ku   = g_ku >> 1;
            g_ex_u = g_ex - 10'sd1;
        end
        g_ret_u = {g_ex_u[7:0], g_ku[23:0]};
        if ((g_ex_u == g_sdx && g_ret_u >= dst_reg) || g_ex_u < g_sdx)
            g_ret_u = dst_reg;

        if (cur_reg == dst_reg || step_reg == '0)
            g_res = dst_reg;
        else if (g_ex < g_sdx || (g_ex == g_sdx && g_src > dst_reg))
            g_res = g_ret_d;
        else
            g_res = g_ret_u;
    end

    // filter gain step; a zero mantissa in the current or target gain stands for the configured minimum
    always_comb
    begin
        f_src = (cur_reg[23:0] == '0) ? filter_minimum_reg : cur_reg;
        f_dst = (dst_reg[23:0] == '0) ? filter_minimum_reg : dst_reg;
        f_wrk = (step_reg[23:0] == '0) ? 24'd1 : step_reg[23:0];

        f_kd    = $signed({2'b00, f_src[23:0]}) - $signed({2'b00, f_wrk});
        f_ret_d = {f_src[31:24], 24'b0} | {{6{f_kd[25]}}, f_kd};
        if (f_ret_d <= f_dst)
            f_ret_d = f_dst;

        // carry out of the mantissa spills into the exponent field
        f_ku    = {1'b0, f_src[23:0]} + {1'b0, f_wrk};
        f_ret_u = {f_src[31:24], 24'b0} | {7'b0, f_ku};
        if (f_ret_u >= f_dst)
            f_ret_u = dst_reg;

        if (cur_reg == dst_reg)
            f_res = dst_reg;
        else if (f_src > f_dst)
            f_res = f_ret_d;
        else
            f_res = f_ret_u;
    end

    // linear integer step, exact sum clamped to the target, then saturate
    always_comb
    begin
        l_dst = {dst_reg[31], dst_reg};
        if (up_reg)
        begin
            l_sum = {cur_reg[31], cur_reg} + {step_reg[31], step_reg};
            l_w   = (l_sum > l_dst) ? l_dst : l_sum;
        end
        else
        begin
            l_sum = {cur_reg[31], cur_reg} - {step_reg[31], step_reg};
            l_w   = (l_sum < l_dst) ? l_dst : l_sum;
        end
        if (l_w[32] != l_w[31])
            l_res = l_w[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            l_res = l_w[31:0];
    end

    always_comb
    begin
        if (op_reg == OP_NONE)
            result_next = cur_reg;
        else if (!ramp_enable_reg)
            result_next = dst_reg;
        else
        begin
            case (op_reg)
                OP_GAIN:   result_next = g_res;
                OP_FILTER: result_next = f_res;
                OP_LINEAR: result_next = l_res;
                default:   result_next = cur_reg;
            endcase
        end
    end

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("request did not produce a result two cycles later");

    a_reached_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && reached) |-> (new_gain == $past(dst_reg)))
        else $error("reached set while result differs from target");

    a_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(op_reg) == OP_NONE) |-> (new_gain == $past(cur_reg)))
        else $error("unused operation changed the gain");

    a_ramp_off: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !$past(ramp_enable_reg) && $past(op_reg) != OP_NONE) |-> reached)
        else $error("ramp disabled but result is not the target");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import pfgr_pkg::*;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic              hit;
    } ramp_result_t;

    // Mirrors the gain ramp step and keeps the results still owed by the block.
    class ramp_checker;
        localparam int MANT_FLOOR = 'h400000;
        localparam int MANT_CEIL  = 'h7FFFFF;

        bit                ramp_on;
        logic [GAIN_W-1:0] floor_gain;
        ramp_result_t      pending[$];
        int                errors;
        int                checked;
        int                bypassed;
        int                op_count[4];

        function new();
            ramp_on    = 1'b1;
            floor_gain = '0;
            errors     = 0;
            checked    = 0;
            bypassed   = 0;
            foreach (op_count[i])
                op_count[i] = 0;
        endfunction

        function void write_register(logic idx, logic [GAIN_W-1:0] val);
            if (idx == CFG_RAMP_ENABLE)
                ramp_on = val[0];
            else
                floor_gain = val;
        endfunction

        function int exp_of(int g);
            int e;
            e = $signed(g[31:24]);
            return e;
        endfunction

        function int mant_of(int g);
            return {8'h00, g[23:0]};
        endfunction

        function int pack_gain(int e, int m);
            return (e << MANT_W) | m;
        endfunction

        function int shift_mant(int m, int n);
            if (n >= MANT_W)
                return 0;
            return m >>> n;
        endfunction

        function int float_step(int src, int dst, int delta);
            int sft, sx, sdx, wrk, kx, ret;
            if (src == dst || delta == 0)
                return dst;
            sx  = exp_of(src);
            sdx = exp_of(dst);
            sft = sx - exp_of(delta);
            if (sft <= 0)
                wrk = shift_mant(mant_of(delta), -sft);
            else
            begin
                sx  = exp_of(delta);
                src = pack_gain(sx, shift_mant(mant_of(src), sft));
                wrk = mant_of(delta);
            end
            if (wrk == 0)
                wrk = 1;
            if (sx < sdx || (sx == sdx && src > dst))
            begin
                kx = mant_of(src) - wrk;
                if (kx < MANT_FLOOR && sx < sdx)
                begin
                    kx = kx << 1;
                    sx = sx + 1;
                end
                ret = pack_gain(sx, kx);
                if ((sx == sdx && ret <= dst) || kx <= 0)
                    ret = dst;
            end
            else
            begin
                kx = mant_of(src) + wrk;
                if (kx > MANT_CEIL)
                begin
                    kx = kx >>> 1;
                    sx = sx - 1;
                end
                ret = pack_gain(sx, kx);
                if ((sx == sdx && ret >= dst) || sx < sdx)
                    ret = dst;
            end
            return ret;
        endfunction

        function int filter_gain_step(int src, int dst, int delta, int minimum);
            int orig_dst, sx, wrk, kx, ret;
            if (src == dst)
                return dst;
            if (mant_of(src) == 0)
                src = minimum;
            orig_dst = dst;
            if (mant_of(dst) == 0)
                dst = minimum;
            sx  = exp_of(src);
            wrk = mant_of(delta);
            if (wrk == 0)
                wrk = 1;
            if (src > dst)
            begin
                kx  = mant_of(src) - wrk;
                ret = pack_gain(sx, kx);
                if (ret <= dst)
                    ret = dst;
            end
            else
            begin
                kx  = mant_of(src) + wrk;
                ret = pack_gain(sx, kx);
                if (ret >= dst)
                    ret = (mant_of(orig_dst) == 0) ? orig_dst : dst;
            end
            return ret;
        endfunction

        function int linear_gain_step(int cur, int dst, int stp, logic up);
            longint w;
            if (up)
            begin
                w = longint'(cur) + longint'(stp);
                if (w > longint'(dst))
                    w = dst;
            end
            else
            begin
                w = longint'(cur) - longint'(stp);
                if (w < longint'(dst))
                    w = dst;
            end
            if (w > 64'sh7FFF_FFFF)
                w = 64'sh7FFF_FFFF;
            if (w < -64'sh8000_0000)
                w = -64'sh8000_0000;
            return int'(w);
        endfunction

        function ramp_result_t predict(logic [OP_W-1:0] op, logic [GAIN_W-1:0] cur,
                                       logic [GAIN_W-1:0] tgt, logic [GAIN_W-1:0] stp,
                                       logic up);
            ramp_result_t r;
            if (op == OP_NONE)
                r.gain = cur;
            else if (!ramp_on)
                r.gain = tgt;
            else if (op == OP_GAIN)
                r.gain = float_step(cur, tgt, stp);
            else if (op == OP_FILTER)
                r.gain = filter_gain_step(cur, tgt, stp, floor_gain);
            else
                r.gain = linear_gain_step(cur, tgt, stp, up);
            r.hit = (r.gain == tgt);
            return r;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [GAIN_W-1:0] cur,
                                   logic [GAIN_W-1:0] tgt, logic [GAIN_W-1:0] stp,
                                   logic up);
            pending.push_back(predict(op, cur, tgt, stp, up));
            op_count[op]++;
            if (!ramp_on)
                bypassed++;
        endfunction

        function void check_result(logic [GAIN_W-1:0] gain, logic hit);
            ramp_result_t e;
            if (pending.size() == 0)
            begin
                $error("result %h with no request pending", gain);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (gain !== e.gain)
            begin
                $error("new_gain mismatch: expected %h, got %h", e.gain, gain);
                errors++;
            end
            if (hit !== e.hit)
            begin
                $error("reached mismatch: expected %b, got %b", e.hit, hit);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     operation;
    logic [GAIN_W-1:0]   current_gain;
    logic [GAIN_W-1:0]   target_gain;
    logic [GAIN_W-1:0]   step_size;
    logic                ramp_up;
    logic                cfg_write;
    logic                cfg_index;
    logic [GAIN_W-1:0]   cfg_data;
    logic                done;
    logic [GAIN_W-1:0]   new_gain;
    logic                reached;

    ramp_checker sb = new();
    int          sender_idle;

    pseudo_float_gain_ramp_step DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .current_gain (current_gain),
        .target_gain  (target_gain),
        .step_size    (step_size),
        .ramp_up      (ramp_up),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .new_gain     (new_gain),
        .reached      (reached)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(new_gain, reached);
            if (start && !busy)
                sb.note_request(operation, current_gain, target_gain, step_size, ramp_up);
            if (cfg_write)
                sb.write_register(cfg_index, cfg_data);
        end
    end

    initial
    begin
        #5_000_000;
        $display("pseudo_float_gain_ramp_step verification failed");
        $finish;
    end

    function automatic logic [GAIN_W-1:0] gain_word(int e, int m);
        return {e[7:0], m[23:0]};
    endfunction

    function automatic int norm_mant();
        return $urandom_range('h7FFFFF, 'h400000);
    endfunction

    // called just after a falling edge; returns just after a falling edge
    task automatic send_request(logic [OP_W-1:0] op, logic [GAIN_W-1:0] cur,
                                logic [GAIN_W-1:0] tgt, logic [GAIN_W-1:0] stp, logic up);
        while ($urandom_range(99) < sender_idle)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start        = 1'b1;
        operation    = op;
        current_gain = cur;
        target_gain  = tgt;
        step_size    = stp;
        ramp_up      = up;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        int guard;
        guard = 0;
        start = 1'b0;
        while (sb.outstanding() != 0 && guard < 1000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(logic idx, logic [GAIN_W-1:0] val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic directed_requests();
        send_request(OP_NONE,   32'h1234_5678, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_request(OP_GAIN,   32'h0560_0000, 32'h0560_0000, 32'h0310_0000, 1'b0);
        send_request(OP_GAIN,   32'h0540_0000, 32'h0470_0000, 32'h0000_0000, 1'b0);
        // step aligned away to nothing
        send_request(OP_GAIN,   32'h0050_0000, 32'h0060_0000, 32'h1E40_0000, 1'b0);
        send_request(OP_GAIN,   32'h0A50_0000, 32'h0A60_0000, 32'h0410_0000, 1'b1);
        send_request(OP_GAIN,   32'h0370_0000, 32'h0540_0000, 32'h0320_0000, 1'b0);
        send_request(OP_GAIN,   32'h0570_0000, 32'h0340_0000, 32'h0530_0000, 1'b1);
        send_request(OP_GAIN,   32'h7F7F_FFFF, 32'h8040_0000, 32'h7F7F_FFFF, 1'b0);
        send_request(OP_GAIN,   32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_GAIN,   32'h0000_0001, 32'h0100_0000, 32'h0080_0000, 1'b0);
        send_request(OP_FILTER, 32'h0600_0000, 32'h0650_0000, 32'h0000_1000, 1'b0);
        send_request(OP_FILTER, 32'h0540_0000, 32'h0700_0000, 32'h00FF_FFFF, 1'b0);
        send_request(OP_FILTER, 32'h0800_0000, 32'h0800_0000, 32'h0000_0010, 1'b0);
        send_request(OP_FILTER, 32'h0440_0000, 32'h0440_0010, 32'h7F00_0000, 1'b1);
        send_request(OP_FILTER, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_request(OP_LINEAR, 32'd100,       32'd1000,      32'd50,        1'b1);
        send_request(OP_LINEAR, 32'd100,       32'd90,        32'd50,        1'b0);
        send_request(OP_LINEAR, 32'h7FFF_FFF0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        // sums past both ends of the signed range
        send_request(OP_LINEAR, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_request(OP_LINEAR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_request(OP_LINEAR, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_request(OP_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    endtask

    // mostly ramps that follow their own predicted gain toward the target
    task automatic random_burst(int quota);
        int               sent, r, e, steps, cur, tgt, stp;
        logic [OP_W-1:0]  op;
        logic             up;
        ramp_result_t     nxt;
        sent = 0;
        while (sent < quota)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                send_request(OP_W'($urandom_range(3)), $urandom, $urandom, $urandom,
                             1'($urandom_range(1)));
                sent++;
            end
            else if (r >= 95)
            begin
                send_request(OP_NONE, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                up = 1'b0;
                if (r < 45)
                begin
                    op  = OP_GAIN;
                    e   = $urandom_range(40) - 20;
                    cur = gain_word(e, ($urandom_range(19) == 0) ? 0 : norm_mant());
                    tgt = gain_word(e + $urandom_range(4) - 2, norm_mant());
                    stp = gain_word(e + $urandom_range(12) - 4,
                                    $urandom_range(1) ? $urandom_range('h3FFFF) : $urandom);
                end
                else if (r < 70)
                begin
                    op  = OP_FILTER;
                    e   = $urandom_range(40) - 20;
                    cur = gain_word(e, ($urandom_range(6) == 0) ? 0 : norm_mant());
                    tgt = gain_word(e + $urandom_range(2) - 1,
                                    ($urandom_range(6) == 0) ? 0 : norm_mant());
                    stp = gain_word($urandom, $urandom_range(1) ? $urandom_range('h20000)
                                                                 : $urandom);
                end
                else
                begin
                    op  = OP_LINEAR;
                    cur = ($urandom_range(9) == 0) ? $urandom
                                                   : int'($urandom_range(2000000)) - 1000000;
                    tgt = ($urandom_range(9) == 0) ? $urandom
                                                   : int'($urandom_range(2000000)) - 1000000;
                    stp = ($urandom_range(9) == 0) ? $urandom : $urandom_range(200000);
                    up  = ($urandom_range(9) == 0) ? 1'($urandom_range(1)) : (tgt > cur);
                end
                steps = $urandom_range(12, 1);
                for (int k = 0; k < steps && sent < quota; k++)
                begin
                    send_request(op, cur, tgt, stp, up);
                    sent++;
                    nxt = sb.predict(op, cur, tgt, stp, up);
                    if (nxt.hit)
                        break;
                    cur = nxt.gain;
                end
            end
        end
    endtask

    initial
    begin
        int                idle_by_phase[6];
        bit                ramp_by_phase[6];
        logic [GAIN_W-1:0] floor_val;
        idle_by_phase = '{12, 12, 88, 88, 0, 0};
        ramp_by_phase = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_GAIN;
        current_gain = '0;
        target_gain  = '0;
        step_size    = '0;
        ramp_up      = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_RAMP_ENABLE;
        cfg_data     = '0;
        sender_idle  = 12;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_requests();
        for (int p = 0; p < 6; p++)
        begin
            wait_all_results();
            sender_idle = idle_by_phase[p];
            case (p)
                1, 3:    floor_val = 32'h8000_0000;
                2, 4:    floor_val = 32'h7FFF_FFFF;
                default: floor_val = gain_word($urandom_range(40) - 20, norm_mant());
            endcase
            write_register(CFG_RAMP_ENABLE, ($urandom & ~32'd1) | ramp_by_phase[p]);
            write_register(CFG_FILTER_MINIMUM, floor_val);
            if (p == 3)
            begin
                random_burst(120);
                wait_all_results();
                random_burst(115);
            end
            else
                random_burst(235);
        end
        wait_all_results();

        if (sb.outstanding() != 0)
            $error("%0d results never arrived", sb.outstanding());
        $display("covered %0d requests: gain %0d, filter %0d, linear %0d, unused op %0d",
                 sb.op_count[0] + sb.op_count[1] + sb.op_count[2] + sb.op_count[3],
                 sb.op_count[OP_GAIN], sb.op_count[OP_FILTER], sb.op_count[OP_LINEAR],
                 sb.op_count[OP_NONE]);
        $display("%0d results checked, %0d with ramping off, six register settings",
                 sb.checked, sb.bypassed);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("pseudo_float_gain_ramp_step verification clean");
        else
            $display("pseudo_float_gain_ramp_step verification failed");
        $finish;
    end

endmodule
